/* rtl/core/ost_pkg.sv */
// Package for the one-shot timer slot bank: sizes, command codes and the
// controller/datapath command and status structs. No dependencies.
package ost_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int CMD_W        = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int DELAY_W      = 31;
  localparam int TICK_W       = 32;

  // Width that holds both a request slot field and any slot index of the bank.
  localparam int SLOT_SEL_W =
    ($clog2(SLOT_COUNT) > SLOT_FIELD_W) ? $clog2(SLOT_COUNT) : SLOT_FIELD_W;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  typedef struct packed {
    logic write_arm;   // load expiry and set active for the addressed slot
    logic write_stop;  // clear active for the addressed slot
    logic capture;     // latch the expired set and clear those slots
    logic load_out;    // move the lowest pending slot into the output register
  } ost_ctrl_t;

  typedef struct packed {
    logic hit_any;      // some active slot expires at or before the presented tick
    logic last_pending; // the pending slot about to be loaded is the final one
    logic out_free;     // output register can take a new result this cycle
  } ost_status_t;

endpackage

/* rtl/core/ost_if.sv */
// Request and result channel interfaces of the timer slot bank.
// Depends on ost_pkg for field widths.
interface ost_req_if;
  logic                             valid;
  logic                             ready;
  logic [ost_pkg::CMD_W-1:0]        cmd;
  logic [ost_pkg::SLOT_FIELD_W-1:0] slot;
  logic [ost_pkg::DELAY_W-1:0]      delay;
  logic [ost_pkg::TICK_W-1:0]       now_tick;

  modport source (output valid, cmd, slot, delay, now_tick, input ready);
  modport sink (input valid, cmd, slot, delay, now_tick, output ready);
endinterface

interface ost_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ost_pkg::SLOT_FIELD_W-1:0] fired_slot;
  logic                             last_fired;

  modport source (output valid, fired_slot, last_fired, input ready);
  modport sink (input valid, fired_slot, last_fired, output ready);
endinterface

/* rtl/core/ost_datapath.sv */
// Slot state, expiry compare, pending set and result register.
// Depends on ost_pkg and ost_rsp_if; driven by ost_controller commands.
module ost_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ost_pkg::SLOT_FIELD_W-1:0] slot,
  input  logic [ost_pkg::DELAY_W-1:0]      delay,
  input  logic [ost_pkg::TICK_W-1:0]       now_tick,
  input  ost_pkg::ost_ctrl_t               ctrl,
  output ost_pkg::ost_status_t             status,
  ost_rsp_if.source                        result
);

  logic [ost_pkg::SLOT_COUNT-1:0] active;
  logic [ost_pkg::TICK_W-1:0]     expiry [ost_pkg::SLOT_COUNT];
  logic [ost_pkg::SLOT_COUNT-1:0] pend;
  logic [ost_pkg::SLOT_COUNT-1:0] hit;
  logic [ost_pkg::SLOT_COUNT-1:0] sel;
  logic [ost_pkg::SLOT_COUNT-1:0] low;
  logic [ost_pkg::SLOT_COUNT-1:0] rest;
  logic [ost_pkg::SLOT_SEL_W-1:0] low_idx;
  logic [ost_pkg::SLOT_SEL_W-1:0] slot_ext;
  logic [ost_pkg::TICK_W-1:0]     arm_expiry;
  logic                           out_valid;
  logic [ost_pkg::SLOT_FIELD_W-1:0] fired_slot;
  logic                           last_fired;

  assign slot_ext   = ost_pkg::SLOT_SEL_W'(slot);
  assign arm_expiry = now_tick + ost_pkg::TICK_W'(delay);

  always_comb begin
    for (int i = 0; i < ost_pkg::SLOT_COUNT; i++) begin
      sel[i] = (slot_ext == ost_pkg::SLOT_SEL_W'(i));
      hit[i] = active[i] && (expiry[i] <= now_tick);
    end
  end

  // Isolate the lowest pending slot and encode it.
  assign low  = pend & (~pend + ost_pkg::SLOT_COUNT'(1));
  assign rest = pend & ~low;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < ost_pkg::SLOT_COUNT; i++) begin
      if (low[i]) low_idx = low_idx | ost_pkg::SLOT_SEL_W'(i);
    end
  end

  assign status.hit_any      = |hit;
  assign status.last_pending = (rest == '0);
  assign status.out_free     = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < ost_pkg::SLOT_COUNT; i++) begin
      if (ctrl.write_arm && sel[i]) expiry[i] <= arm_expiry;
    end
    if (ctrl.load_out) begin
      fired_slot <= low_idx[ost_pkg::SLOT_FIELD_W-1:0];
      last_fired <= (rest == '0);
    end
    if (rst) begin
      active    <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.write_arm) active <= active | sel;
      else if (ctrl.write_stop) active <= active & ~sel;
      else if (ctrl.capture) active <= active & ~hit;
      if (ctrl.capture) pend <= hit;
      else if (ctrl.load_out) pend <= rest;
      if (ctrl.load_out) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  assign result.valid      = out_valid;
  assign result.fired_slot = fired_slot;
  assign result.last_fired = last_fired;

  a_capture_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |-> (pend == '0))
    else $error("tick captured while results still pending");
  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> (pend != '0))
    else $error("result loaded with no pending slot");
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out && status.last_pending |=> (pend == '0))
    else $error("pending set not empty after final result");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |=> result.valid)
    else $error("loaded result not presented");

endmodule

/* rtl/core/ost_controller.sv */
// Controller for the timer slot bank: decodes requests and sequences result
// emission. Depends on ost_pkg; commands ost_datapath.
module ost_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [ost_pkg::CMD_W-1:0] req_cmd,
  output logic                      req_ready,
  input  ost_pkg::ost_status_t      status,
  output ost_pkg::ost_ctrl_t        ctrl
);

  typedef enum logic {
    ST_IDLE,
    ST_FIRE
  } state_t;

  state_t state;
  logic   accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    ctrl.write_arm  = accept && (req_cmd == ost_pkg::CMD_ARM);
    ctrl.write_stop = accept && (req_cmd == ost_pkg::CMD_STOP);
    ctrl.capture    = accept && (req_cmd == ost_pkg::CMD_TICK);
    ctrl.load_out   = (state == ST_FIRE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctrl.capture && status.hit_any) state <= ST_FIRE;
        end
        ST_FIRE: begin
          if (status.out_free && status.last_pending) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/one_shot_timer_slots_core.sv */
// Bank of one-shot timer slots. Arm and stop requests update the addressed slot.
// A tick request compares all slots, latches the expired set as pending, then
// emits one result per cycle, one per expired slot (up to 16), through the
// output register, slower while the result side stalls; the first result is
// registered in the pending set and sequencer state first. Synchronous reset
// clears active bits, pending set, output valid and the sequencer; expiry registers are not reset.
module one_shot_timer_slots_core (
  input  logic       clk,
  input  logic       rst,
  ost_req_if.sink    request,
  ost_rsp_if.source  result
);

  // Command and status between the sequencer and the slot datapath.
  ost_pkg::ost_ctrl_t   ctrl;
  ost_pkg::ost_status_t status;

  // Sequencer: accepts requests only while no tick is emitting results,
  // so expired slots drain in ascending order before the next request.
  ost_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_cmd   (request.cmd),
    .req_ready (request.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  // Datapath: slot registers, parallel expiry compare, pending set with
  // lowest-first pick, and the registered result stage that holds a result
  // while the sink stalls; once the final result is loaded, new requests are let in.
  ost_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .slot     (request.slot),
    .delay    (request.delay),
    .now_tick (request.now_tick),
    .ctrl     (ctrl),
    .status   (status),
    .result   (result)
  );

endmodule
